// ===== hdl/phlm_pkg.sv =====
// ----------------------------------------------------------------------------
// phlm_pkg: shared definitions for the peak hold level meter
// Fixed-point sizes, function and register codes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package phlm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_LEDS  = 256;

	localparam int VAL_W     = FRAC_BITS + 1;
	localparam int LED_W     = $clog2(MAX_LEDS + 1);
	localparam int ACC_W     = VAL_W + LED_W;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(((DIV_STEPS > LED_W) ? DIV_STEPS : LED_W) + 1);

	localparam int SMP_W  = 32;
	localparam int STEP_W = 17;
	localparam int HOLD_W = 10;
	localparam int LCNT_W = 9;
	localparam int CIDX_W = 3;

	localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(1) << FRAC_BITS;
	localparam logic [ACC_W-1:0] HALF_SCALE = ACC_W'(1) << (FRAC_BITS - 1);

	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_MIN_LEVEL    = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_MAX_LEVEL    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_FALLOFF_STEP = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_HOLD_COUNT   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_LED_COUNT    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_DIV,
		ST_UPD,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/peak_hold_level_meter.sv =====
// ----------------------------------------------------------------------------
// peak_hold_level_meter: LED bar meter with peak hold and linear falloff
//
// Input channel (in_valid/in_ready) takes one command per transfer: func 0 is
// a level sample in signed Q16.16, func 1 a falloff tick, func 2 a clear.
// Output channel (out_valid/out_ready) returns one result per command:
// shown and peak level in unsigned Q1.16, lit LED count, peak LED and ticks_needed.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// used only while no command is in flight.
// A sample passes from the input transfer to out_valid through a clamp
// step, a bit-serial restoring divider (one quotient bit a cycle), a state
// update step, a bit-serial LED multiplier (one LED count bit a cycle) and
// an output load step. Ticks, clears, the unused code and samples over an
// empty range skip the divider. One command is in work at a time, so a
// new command is taken only after the last one has been loaded into the
// output register.
// The next command is taken while a result still waits in the output
// register; if the receiver stalls, a finished command holds in its last
// step until the output register is free.
// Reset clears all meter state and loads the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_level_meter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [1:0]                          func,
	input  wire logic signed [phlm_pkg::SMP_W-1:0]   sample_value,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [phlm_pkg::VAL_W-1:0]          shown_level,
	output      logic [phlm_pkg::VAL_W-1:0]          peak_value,
	output      logic [phlm_pkg::LED_W-1:0]          lit_leds,
	output      logic [phlm_pkg::LED_W-1:0]          peak_led,
	output      logic                                ticks_needed,
	input  wire logic                                cfg_we,
	input  wire logic [phlm_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [phlm_pkg::SMP_W-1:0]          cfg_data
);

	phlm_pkg::state_t state_q, state_d;

	logic signed [phlm_pkg::SMP_W-1:0] min_q, max_q;
	logic [phlm_pkg::STEP_W-1:0]       step_q;
	logic [phlm_pkg::HOLD_W-1:0]       holdc_q, hold_left_q;
	logic [phlm_pkg::LCNT_W-1:0]       ledc_q;
	logic [phlm_pkg::VAL_W-1:0]        target_q, shown_q, peak_q;
	logic [phlm_pkg::CNT_W-1:0]        cnt_q;
	logic                              out_valid_q;

	logic [1:0]                        func_q;
	logic signed [phlm_pkg::SMP_W-1:0] sample_q;
	logic [phlm_pkg::SMP_W:0]          rem_q;
	logic [phlm_pkg::SMP_W-1:0]        span_q;
	logic [phlm_pkg::VAL_W-1:0]        quot_q;
	logic [phlm_pkg::LED_W-1:0]        nsr_q;
	logic [phlm_pkg::ACC_W-1:0]        acc_shown_q, acc_peak_q;
	logic [phlm_pkg::VAL_W-1:0]        shown_out_q, peak_out_q;
	logic [phlm_pkg::LED_W-1:0]        lit_out_q, pled_out_q;
	logic                              ticks_out_q;

	logic                              div_last, mul_last, load_out, cnt_run;
	logic signed [phlm_pkg::SMP_W-1:0] clamped;
	logic [phlm_pkg::SMP_W:0]          diff_c, span_c;
	logic                              empty_rng;
	logic [phlm_pkg::SMP_W:0]          rem_sh;
	logic [phlm_pkg::SMP_W+1:0]        trial;
	logic                              q_bit;
	logic                              falloff_on;
	logic [phlm_pkg::SMP_W-1:0]        step_w;
	logic [phlm_pkg::VAL_W-1:0]        step_eff;
	logic [phlm_pkg::VAL_W-1:0]        smp_v, fall_gap;
	logic                              keep_shown;
	logic [phlm_pkg::LED_W-1:0]        n_eff;
	logic [phlm_pkg::ACC_W-1:0]        sum_shown, sum_peak;

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phlm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		div_last = (cnt_q == phlm_pkg::CNT_W'(phlm_pkg::DIV_STEPS - 1));
		mul_last = (cnt_q == phlm_pkg::CNT_W'(phlm_pkg::LED_W - 1));
		cnt_run  = 1'b0;
		unique case (state_q)
			phlm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = phlm_pkg::ST_CLAMP;
			end
			phlm_pkg::ST_CLAMP: begin
				if (func_q == phlm_pkg::FUNC_SAMPLE && !empty_rng) state_d = phlm_pkg::ST_DIV;
				else state_d = phlm_pkg::ST_UPD;
			end
			phlm_pkg::ST_DIV: begin
				cnt_run = !div_last;
				if (div_last) state_d = phlm_pkg::ST_UPD;
			end
			phlm_pkg::ST_UPD: begin
				state_d = phlm_pkg::ST_MUL;
			end
			phlm_pkg::ST_MUL: begin
				cnt_run = !mul_last;
				if (mul_last) state_d = phlm_pkg::ST_DONE;
			end
			phlm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = phlm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = phlm_pkg::ST_IDLE;
			end
		endcase
	end

	// clamp and range
	always_comb begin
		if (sample_q < min_q) clamped = min_q;
		else if (sample_q > max_q) clamped = max_q;
		else clamped = sample_q;
		diff_c    = {clamped[phlm_pkg::SMP_W-1], clamped} - {min_q[phlm_pkg::SMP_W-1], min_q};
		span_c    = {max_q[phlm_pkg::SMP_W-1], max_q} - {min_q[phlm_pkg::SMP_W-1], min_q};
		empty_rng = !(max_q > min_q);
	end

	// divider step
	always_comb begin
		rem_sh = (cnt_q == '0) ? rem_q : {rem_q[phlm_pkg::SMP_W-1:0], 1'b0};
		trial  = {1'b0, rem_sh} - {2'b00, span_q};
		q_bit  = !trial[phlm_pkg::SMP_W+1];
	end

	// update helpers
	always_comb begin
		falloff_on = (step_q != '0);
		step_w     = phlm_pkg::SMP_W'(step_q);
		step_eff   = (step_w > phlm_pkg::SMP_W'(phlm_pkg::FULL_SCALE)) ?
			phlm_pkg::FULL_SCALE : phlm_pkg::VAL_W'(step_w);
		keep_shown = falloff_on && (quot_q < shown_q);
		smp_v      = keep_shown ? shown_q : quot_q;
		fall_gap   = shown_q - target_q;
		n_eff      = (phlm_pkg::SMP_W'(ledc_q) > phlm_pkg::SMP_W'(phlm_pkg::MAX_LEDS)) ?
			phlm_pkg::LED_W'(phlm_pkg::MAX_LEDS) : phlm_pkg::LED_W'(ledc_q);
		sum_shown  = acc_shown_q + phlm_pkg::HALF_SCALE;
		sum_peak   = acc_peak_q + phlm_pkg::HALF_SCALE;
	end

	// configuration, meter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			max_q       <= phlm_pkg::SMP_W'(65536);
			step_q      <= '0;
			holdc_q     <= '0;
			ledc_q      <= phlm_pkg::LCNT_W'(32);
			target_q    <= '0;
			shown_q     <= '0;
			peak_q      <= '0;
			hold_left_q <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_run ? cnt_q + 1'b1 : '0;

			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					phlm_pkg::CFG_MIN_LEVEL:    min_q  <= cfg_data;
					phlm_pkg::CFG_MAX_LEVEL:    max_q  <= cfg_data;
					phlm_pkg::CFG_FALLOFF_STEP: step_q <= cfg_data[phlm_pkg::STEP_W-1:0];
					phlm_pkg::CFG_HOLD_COUNT: begin
						holdc_q     <= cfg_data[phlm_pkg::HOLD_W-1:0];
						hold_left_q <= '0;
					end
					phlm_pkg::CFG_LED_COUNT:    ledc_q <= cfg_data[phlm_pkg::LCNT_W-1:0];
					default: ;
				endcase
			end

			if (state_q == phlm_pkg::ST_UPD) begin
				unique case (func_q)
					phlm_pkg::FUNC_SAMPLE: begin
						target_q <= quot_q;
						shown_q  <= smp_v;
						if (holdc_q != '0) begin
							if (smp_v > peak_q) begin
								peak_q      <= smp_v;
								hold_left_q <= holdc_q;
							end else if (hold_left_q == '0) begin
								peak_q <= smp_v;
							end
						end
					end
					phlm_pkg::FUNC_TICK: begin
						if (hold_left_q != '0) hold_left_q <= hold_left_q - 1'b1;
						if (falloff_on && shown_q > target_q) begin
							if (fall_gap > step_eff) shown_q <= shown_q - step_eff;
							else shown_q <= target_q;
						end
					end
					phlm_pkg::FUNC_CLEAR: begin
						target_q    <= '0;
						shown_q     <= '0;
						peak_q      <= '0;
						hold_left_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			phlm_pkg::ST_IDLE: begin
				if (in_valid) begin
					func_q   <= func;
					sample_q <= sample_value;
				end
			end
			phlm_pkg::ST_CLAMP: begin
				rem_q  <= {1'b0, diff_c[phlm_pkg::SMP_W-1:0]};
				span_q <= span_c[phlm_pkg::SMP_W-1:0];
				quot_q <= '0;
			end
			phlm_pkg::ST_DIV: begin
				rem_q  <= q_bit ? trial[phlm_pkg::SMP_W:0] : rem_sh;
				quot_q <= {quot_q[phlm_pkg::VAL_W-2:0], q_bit};
			end
			phlm_pkg::ST_UPD: begin
				nsr_q       <= n_eff;
				acc_shown_q <= '0;
				acc_peak_q  <= '0;
			end
			phlm_pkg::ST_MUL: begin
				nsr_q       <= {nsr_q[phlm_pkg::LED_W-2:0], 1'b0};
				acc_shown_q <= {acc_shown_q[phlm_pkg::ACC_W-2:0], 1'b0} +
					(nsr_q[phlm_pkg::LED_W-1] ? phlm_pkg::ACC_W'(shown_q) : '0);
				acc_peak_q  <= {acc_peak_q[phlm_pkg::ACC_W-2:0], 1'b0} +
					(nsr_q[phlm_pkg::LED_W-1] ? phlm_pkg::ACC_W'(peak_q) : '0);
			end
			phlm_pkg::ST_DONE: begin
				if (load_out) begin
					shown_out_q <= shown_q;
					peak_out_q  <= peak_q;
					lit_out_q   <= sum_shown[phlm_pkg::FRAC_BITS+phlm_pkg::LED_W-1:phlm_pkg::FRAC_BITS];
					pled_out_q  <= (hold_left_q != '0) ?
						sum_peak[phlm_pkg::FRAC_BITS+phlm_pkg::LED_W-1:phlm_pkg::FRAC_BITS] : '0;
					ticks_out_q <= (hold_left_q != '0) || (shown_q > target_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign shown_level  = shown_out_q;
	assign peak_value   = peak_out_q;
	assign lit_leds     = lit_out_q;
	assign peak_led     = pled_out_q;
	assign ticks_needed = ticks_out_q;

	// falloff never takes the shown level below the target
	a_shown_ge_target: assert property (@(posedge clk) disable iff (!arst_n)
		shown_q >= target_q)
		else $error("shown level below target");

	a_levels_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		target_q <= phlm_pkg::FULL_SCALE && shown_q <= phlm_pkg::FULL_SCALE &&
		peak_q <= phlm_pkg::FULL_SCALE)
		else $error("level above full scale");

	a_hold_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hold_left_q <= holdc_q)
		else $error("hold counter above hold count");

	a_quot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == phlm_pkg::ST_UPD |-> quot_q <= phlm_pkg::FULL_SCALE)
		else $error("scaled sample above full scale");

	a_div_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == phlm_pkg::ST_DIV && div_last |=> state_q == phlm_pkg::ST_UPD)
		else $error("divider did not hand over to update");

endmodule

`default_nettype wire

// ===== test/phlm_checker.sv =====
// ----------------------------------------------------------------------------
// phlm_checker: result checker for the peak hold level meter
// Watches the command, result and configuration ports. For each command
// transfer it steps its own model of the meter and queues the expected
// reading. Each result transfer is compared field by field with the oldest
// queued reading. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module phlm_checker
	import phlm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [1:0]               func,
	input  logic signed [SMP_W-1:0]  sample_value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [VAL_W-1:0]         shown_level,
	input  logic [VAL_W-1:0]         peak_value,
	input  logic [LED_W-1:0]         lit_leds,
	input  logic [LED_W-1:0]         peak_led,
	input  logic                     ticks_needed,
	input  logic                     cfg_we,
	input  logic [CIDX_W-1:0]        cfg_index,
	input  logic [SMP_W-1:0]         cfg_data,
	output int                       fail_count,
	output int                       pending,
	output int                       readings_checked
);

	typedef struct {
		logic [VAL_W-1:0] shown;
		logic [VAL_W-1:0] peak;
		logic [LED_W-1:0] lit;
		logic [LED_W-1:0] pled;
		logic             need;
	} reading_t;

	logic signed [SMP_W-1:0] min_lvl;
	logic signed [SMP_W-1:0] max_lvl;
	logic [STEP_W-1:0]       step_cfg;
	logic [HOLD_W-1:0]       hold_cfg;
	logic [LCNT_W-1:0]       leds_cfg;

	logic [VAL_W-1:0]  target_lvl;
	logic [VAL_W-1:0]  shown_lvl;
	logic [VAL_W-1:0]  peak_lvl;
	logic [HOLD_W-1:0] hold_left;

	reading_t due_readings[$];

	task automatic report(string msg);
		if (fail_count < 50) $display("phlm_checker: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("result %0d: %s is %0d, expected %0d",
				readings_checked, name, got, want));
	endtask

	function automatic logic [VAL_W-1:0] scaled_level(logic signed [SMP_W-1:0] raw);
		longint lo;
		longint hi;
		longint v;
		logic [63:0] span;
		logic [63:0] num;
		lo = min_lvl;
		hi = max_lvl;
		v = raw;
		if (hi <= lo) return '0;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		span = 64'(hi - lo);
		num = 64'(v - lo) << FRAC_BITS;
		return VAL_W'(num / span);
	endfunction

	function automatic logic [VAL_W-1:0] falloff_rate();
		return (step_cfg > FULL_SCALE) ? FULL_SCALE : VAL_W'(step_cfg);
	endfunction

	function automatic logic [LED_W-1:0] bar_leds(logic [VAL_W-1:0] lvl);
		logic [63:0] n;
		n = (leds_cfg > MAX_LEDS) ? 64'(MAX_LEDS) : 64'(leds_cfg);
		return LED_W'((n * lvl + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
	endfunction

	function automatic reading_t advance_meter(logic [1:0] op, logic signed [SMP_W-1:0] raw);
		logic [VAL_W-1:0] lvl;
		logic [VAL_W-1:0] rate;
		reading_t r;
		rate = falloff_rate();
		case (op)
			FUNC_SAMPLE: begin
				lvl = scaled_level(raw);
				target_lvl = lvl;
				// a falling bar keeps its level and feeds that to the peak logic
				if (rate != 0 && lvl < shown_lvl)
					lvl = shown_lvl;
				else
					shown_lvl = lvl;
				if (hold_cfg != 0) begin
					if (lvl > peak_lvl) begin
						peak_lvl = lvl;
						hold_left = hold_cfg;
					end else if (hold_left == 0) begin
						peak_lvl = lvl;
					end
				end
			end
			FUNC_TICK: begin
				if (hold_left != 0) hold_left--;
				if (rate != 0 && shown_lvl > target_lvl) begin
					if (shown_lvl - target_lvl > rate)
						shown_lvl = shown_lvl - rate;
					else
						shown_lvl = target_lvl;
				end
			end
			FUNC_CLEAR: begin
				target_lvl = '0;
				shown_lvl = '0;
				peak_lvl = '0;
				hold_left = '0;
			end
			default: ;
		endcase
		r.shown = shown_lvl;
		r.peak = peak_lvl;
		r.lit = bar_leds(shown_lvl);
		r.pled = (hold_left != 0) ? bar_leds(peak_lvl) : '0;
		r.need = (hold_left != 0) || (shown_lvl > target_lvl);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			min_lvl = '0;
			max_lvl = 32'sd65536;
			step_cfg = '0;
			hold_cfg = '0;
			leds_cfg = 9'd32;
			target_lvl = '0;
			shown_lvl = '0;
			peak_lvl = '0;
			hold_left = '0;
			due_readings.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				readings_checked++;
				if (due_readings.size() == 0) begin
					report("result transfer with no command outstanding");
				end else begin
					want = due_readings.pop_front();
					check_field("shown_level", 32'(shown_level), 32'(want.shown));
					check_field("peak_value", 32'(peak_value), 32'(want.peak));
					check_field("lit_leds", 32'(lit_leds), 32'(want.lit));
					check_field("peak_led", 32'(peak_led), 32'(want.pled));
					check_field("ticks_needed", 32'(ticks_needed), 32'(want.need));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_LEVEL:    min_lvl = cfg_data;
					CFG_MAX_LEVEL:    max_lvl = cfg_data;
					CFG_FALLOFF_STEP: step_cfg = cfg_data[STEP_W-1:0];
					CFG_HOLD_COUNT: begin
						hold_cfg = cfg_data[HOLD_W-1:0];
						hold_left = '0;
					end
					CFG_LED_COUNT:    leds_cfg = cfg_data[LCNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_readings.push_back(advance_meter(func, sample_value));
			pending <= due_readings.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the peak hold level meter
// Drives commands and configuration into the meter while a checker beside
// it predicts every reading. A directed opening covers range ends, every
// command and the corner settings; then random phases each pick a new
// setting and send random commands under random idling on both channels,
// with one long receiver stall and one full drain mid-phase.
// ----------------------------------------------------------------------------
module tb;
	import phlm_pkg::*;

	localparam logic [1:0]        FUNC_NONE       = 2'd3;
	localparam logic [CIDX_W-1:0] CFG_SPARE       = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_NONE        = 3'd7;
	localparam int                RUN_ITEMS       = 2000;
	localparam int                HOLD_OFF_CYCLES = 300;
	localparam int                DRAIN_CYCLES    = 40;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              func = FUNC_SAMPLE;
	logic signed [SMP_W-1:0] sample_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [VAL_W-1:0]        shown_level;
	logic [VAL_W-1:0]        peak_value;
	logic [LED_W-1:0]        lit_leds;
	logic [LED_W-1:0]        peak_led;
	logic                    ticks_needed;
	logic                    cfg_we = 1'b0;
	logic [CIDX_W-1:0]       cfg_index = CFG_MIN_LEVEL;
	logic [SMP_W-1:0]        cfg_data = '0;

	int     fail_count;
	int     pending;
	int     readings_checked;
	bit     calm = 1'b0;
	bit     hold_req = 1'b0;
	longint cur_min = 0;
	longint cur_max = 65536;
	int     items_sent = 0;
	int     phases = 0;

	peak_hold_level_meter u_top (.*);

	phlm_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(4 * 1000000);
		$display("[peak_hold_level_meter] ERROR");
		$finish;
	end

	function automatic int idle_gap();
		if (calm || $urandom_range(99) >= 16) return 0;
		return $urandom_range(1, 6);
	endfunction

	task automatic send_item(logic [1:0] op, logic signed [SMP_W-1:0] raw);
		int gap;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		sample_value <= raw;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [SMP_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_meter(longint lo, longint hi, logic [31:0] step, logic [31:0] hold,
			logic [31:0] leds);
		drain();
		write_reg(CFG_MIN_LEVEL, 32'(lo));
		write_reg(CFG_MAX_LEVEL, 32'(hi));
		write_reg(CFG_FALLOFF_STEP, step);
		write_reg(CFG_HOLD_COUNT, hold);
		write_reg(CFG_LED_COUNT, leds);
		if ($urandom_range(3) == 0) write_reg(CFG_SPARE + CIDX_W'($urandom_range(2)), $urandom);
		cfg_we <= 1'b0;
		cur_min = lo;
		cur_max = hi;
		phases++;
	endtask

	function automatic logic signed [SMP_W-1:0] pick_sample();
		logic [63:0] r;
		longint lo;
		longint hi;
		r = {$urandom, $urandom};
		lo = (cur_min < cur_max) ? cur_min : cur_max;
		hi = (cur_min < cur_max) ? cur_max : cur_min;
		case ($urandom_range(9))
			0: return SMP_W'(r);
			1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			2: return SMP_W'(cur_min);
			3: return SMP_W'(cur_max);
			default: return SMP_W'(lo + longint'(r % 64'(hi - lo + 1)));
		endcase
	endfunction

	task automatic random_meter();
		longint a;
		longint b;
		logic [31:0] step;
		logic [31:0] hold;
		logic [31:0] leds;
		case ($urandom_range(5))
			0: begin
				a = 0;
				b = 65536;
			end
			1: begin
				a = longint'(32'sh8000_0000);
				b = 2147483647;
			end
			2: begin
				a = longint'($signed($urandom));
				b = a;
			end
			3: begin
				a = $urandom_range(70000, 1);
				b = -a;
			end
			default: begin
				a = longint'($signed($urandom));
				b = a + $urandom_range(1, 1 << 20);
				if (b > 2147483647) b = 2147483647;
			end
		endcase
		case ($urandom_range(7))
			0: step = 0;
			1: step = 1;
			2: step = 7864;
			3: step = 65536;
			4: step = 65537 + $urandom_range(65534);
			default: step = $urandom_range(1, 20000);
		endcase
		case ($urandom_range(5))
			0: hold = 0;
			1: hold = 1;
			2: hold = 1000;
			3: hold = 1023;
			default: hold = $urandom_range(2, 30);
		endcase
		case ($urandom_range(5))
			0: leds = 0;
			1: leds = 1;
			2: leds = 256;
			3: leds = $urandom_range(257, 511);
			default: leds = $urandom_range(2, 255);
		endcase
		set_meter(a, b, step, hold, leds);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 48)
			send_item(FUNC_SAMPLE, pick_sample());
		else if (pick < 88)
			send_item(FUNC_TICK, $urandom);
		else if (pick < 94)
			send_item(FUNC_CLEAR, $urandom);
		else
			send_item(FUNC_NONE, $urandom);
	endtask

	// receiver side
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	initial begin
		int k;
		int n;
		int first;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-up settings
		send_item(FUNC_SAMPLE, 32'sd32768);
		send_item(FUNC_SAMPLE, 32'sh7FFF_FFFF);
		send_item(FUNC_SAMPLE, 32'sh8000_0000);
		send_item(FUNC_TICK, '0);
		send_item(FUNC_NONE, 32'sh5A5A_A5A5);

		// peak capture, hold expiry and falloff
		set_meter(0, 65536, 7864, 3, 32);
		send_item(FUNC_SAMPLE, 32'sd65536);
		send_item(FUNC_SAMPLE, 32'sd16384);
		repeat (4) send_item(FUNC_TICK, '0);
		send_item(FUNC_SAMPLE, 32'sd8192);
		send_item(FUNC_CLEAR, '1);
		send_item(FUNC_SAMPLE, 32'sd40000);
		send_item(FUNC_SAMPLE, 32'sd0);

		// falloff off mid-fall, hold count rewrite, writes to unused indexes
		drain();
		write_reg(CFG_FALLOFF_STEP, '0);
		write_reg(CFG_HOLD_COUNT, 32'd2);
		write_reg(CFG_SPARE, '1);
		write_reg(CFG_NONE, '1);
		cfg_we <= 1'b0;
		send_item(FUNC_TICK, '0);
		send_item(FUNC_TICK, '0);

		// oversized step, LED count above max
		set_meter(-65536, 65536, 32'h1FFFF, 5, 511);
		send_item(FUNC_SAMPLE, 32'sd65536);
		send_item(FUNC_SAMPLE, -32'sd65536);
		send_item(FUNC_TICK, '0);

		// empty and inverted ranges, no LEDs
		set_meter(1000, 1000, 7864, 4, 0);
		send_item(FUNC_SAMPLE, 32'sd5000);
		send_item(FUNC_SAMPLE, -32'sd5000);
		set_meter(65536, 0, 0, 4, 256);
		send_item(FUNC_SAMPLE, 32'sd0);

		// full input range, hold count of 1000, smallest step
		set_meter(longint'(32'sh8000_0000), 2147483647, 1, 1000, 256);
		send_item(FUNC_SAMPLE, 32'sh7FFF_FFFF);
		send_item(FUNC_SAMPLE, 32'sh8000_0000);
		send_item(FUNC_TICK, '0);

		first = items_sent;
		k = 0;
		while (items_sent < first + RUN_ITEMS) begin
			random_meter();
			calm = (k == 5);
			if (k == 3) hold_req = 1'b1;
			n = $urandom_range(60, 140);
			repeat (n / 2) random_item();
			if (k == 8) drain();
			repeat (n - n / 2) random_item();
			k++;
		end
		calm = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("tb: %0d commands over %0d meter settings, %0d results compared",
			items_sent, phases, readings_checked);
		$display("tb: samples, ticks, clears and the unused code under stalls and back-pressure");
		if (fail_count == 0)
			$display("[peak_hold_level_meter] OK");
		else
			$display("[peak_hold_level_meter] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/phlm_pkg.sv
hdl/peak_hold_level_meter.sv
test/phlm_checker.sv
test/tb.sv
